// ===== design/dual_mode_slot_buffer_assert.svh =====
// Assertion macros shared by the slot buffer controller and datapath.
// Expects clk and arst_n in scope at the point of use.
`ifndef DUAL_MODE_SLOT_BUFFER_ASSERT_SVH
`define DUAL_MODE_SLOT_BUFFER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMSB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dmsb_pkg.sv =====
// Shared types and codes for the dual-mode slot buffer.
// No dependencies; used by the channel interfaces and all modules.
package dmsb_pkg;

	localparam int FIELD_BITS    = 64;
	localparam int STATUS_BITS   = 2;
	localparam int CFG_DATA_BITS = 5;
	localparam logic [CFG_DATA_BITS-1:0] DEPTH_RESET = 5'd16;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic {
		CFG_MODE  = 1'b0,
		CFG_DEPTH = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic accept;
	} dmsb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
	} dmsb_sts_t;

endpackage

// ===== design/dmsb_in_if.sv =====
// Request channel: operation and write word with valid/ready.
// Depends on dmsb_pkg.
interface dmsb_in_if;
	import dmsb_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic [FIELD_BITS-1:0] write_data;

	modport source (output valid, operation, write_data, input ready);
	modport sink   (input valid, operation, write_data, output ready);
endinterface

// ===== design/dmsb_out_if.sv =====
// Response channel: read word and status with valid/ready.
// Depends on dmsb_pkg.
interface dmsb_out_if;
	import dmsb_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [FIELD_BITS-1:0]  read_data;
	logic [STATUS_BITS-1:0] status;

	modport source (output valid, read_data, status, input ready);
	modport sink   (input valid, read_data, status, output ready);
endinterface

// ===== design/dual_mode_slot_buffer.sv =====
// Top level of the dual-mode slot buffer: ring FIFO or four-slot buffer.
// Depends on dmsb_pkg, dmsb_in_if, dmsb_out_if, dmsb_ctrl and dmsb_dp.
//
//   channel  | dir | payload                       | transfer when
//   ---------+-----+-------------------------------+-------------------
//   req      | in  | operation, write_data         | req.valid & req.ready
//   rsp      | out | read_data, status             | rsp.valid & rsp.ready
//   cfg      | in  | cfg_index, cfg_wdata          | cfg_we
//
// Each request gives one response on the next cycle; reads come from the
// single registered read port of the entry memory, which sets that latency.
// With rsp.ready held high a request can transfer every cycle.
// After reset a clearing sweep zeroes every memory entry, one entry a cycle;
// req.ready stays low meanwhile (config writes still land).
// A stalled response holds its payload and blocks the next request.
module dual_mode_slot_buffer #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	dmsb_in_if.sink                            req,
	dmsb_out_if.source                         rsp,
	input  logic                               cfg_we,
	input  dmsb_pkg::cfg_idx_t                 cfg_index,
	input  logic [dmsb_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import dmsb_pkg::*;

	dmsb_cmd_t cmd;
	dmsb_sts_t sts;
	logic      req_ready;
	logic      rsp_valid;

	// FSM owns the handshakes; datapath only sees accept/clear commands
	dmsb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dmsb_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.operation  (req.operation),
		.write_data (req.write_data),
		.cmd        (cmd),
		.sts        (sts),
		.read_data  (rsp.read_data),
		.status     (rsp.status)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

endmodule

// ===== design/dmsb_ctrl.sv =====
// Controller FSM: clearing sweep, request acceptance, response handshake.
// Depends on dmsb_pkg and dual_mode_slot_buffer_assert.svh.
`include "dual_mode_slot_buffer_assert.svh"

module dmsb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dmsb_pkg::dmsb_cmd_t cmd,
	input  dmsb_pkg::dmsb_sts_t sts
);
	import dmsb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				rsp_valid = 1'b1;
				// next request may enter on the cycle the response leaves
				req_ready = rsp_ready;
				if (rsp_ready && !req_valid) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		cmd.accept = req_ready & req_valid;
	end

	`DMSB_ASSERT_NEXT(a_accept_gives_result, cmd.accept, rsp_valid, "accepted request left no response")
	`DMSB_ASSERT_NOW(a_no_accept_in_clear, cmd.clear, !cmd.accept, "request taken during clear sweep")
	`DMSB_ASSERT_NEXT(a_clear_ends, (state_q == S_CLEAR) && sts.clear_done, state_q == S_IDLE, "clear sweep did not end")

endmodule

// ===== design/dmsb_dp.sv =====
// Datapath: config registers, ring pointers, four-slot bits, entry memory.
// Depends on dmsb_pkg and dual_mode_slot_buffer_assert.svh.
`include "dual_mode_slot_buffer_assert.svh"

module dmsb_dp #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  dmsb_pkg::cfg_idx_t                     cfg_index,
	input  logic [dmsb_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
	input  logic                                   operation,
	input  logic [dmsb_pkg::FIELD_BITS-1:0]        write_data,
	input  dmsb_pkg::dmsb_cmd_t                    cmd,
	output dmsb_pkg::dmsb_sts_t                    sts,
	output logic [dmsb_pkg::FIELD_BITS-1:0]        read_data,
	output logic [dmsb_pkg::STATUS_BITS-1:0]       status
);
	import dmsb_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = (CW > CFG_DATA_BITS) ? CW : CFG_DATA_BITS;

	// config
	logic                     mode_q;
	logic [CFG_DATA_BITS-1:0] depth_q;

	// ring state
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] fill_q;

	// four-slot state
	logic       latest_q;
	logic       reading_q;
	logic [1:0] newest_q;

	logic [AW-1:0] clr_ptr_q;

	// memory and response payload
	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] mem_rd_q;
	status_t              status_q;
	logic                 rd_ok_q;

	logic [DW-1:0]        depth_ext;
	logic [CW-1:0]        d_eff;
	logic [CW-1:0]        wp_inc, rp_inc;
	logic [AW-1:0]        wp_next, rp_next;
	logic                 full, empty, is_read;
	logic                 w_pair, w_slot, r_pair, r_slot;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;
	status_t              status_d;
	logic                 rd_ok_d;

	always_comb begin
		depth_ext = DW'(depth_q);
		if (depth_ext == '0) begin
			d_eff = CW'(1);
		end else if (depth_ext > DW'(DEPTH)) begin
			d_eff = CW'(DEPTH);
		end else begin
			d_eff = CW'(depth_ext);
		end
	end

	assign wp_inc  = CW'(wp_q) + CW'(1);
	assign rp_inc  = CW'(rp_q) + CW'(1);
	assign wp_next = (wp_inc >= d_eff) ? '0 : wp_inc[AW-1:0];
	assign rp_next = (rp_inc >= d_eff) ? '0 : rp_inc[AW-1:0];
	assign full    = (fill_q >= d_eff);
	assign empty   = (fill_q == '0);
	assign is_read = (operation == OP_READ);

	// writer takes the pair not being read, the slot not written last
	assign w_pair = ~reading_q;
	assign w_slot = ~newest_q[w_pair];
	assign r_pair = latest_q;
	assign r_slot = newest_q[r_pair];

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = clr_ptr_q;
		mem_raddr = rp_q;
		mem_wdata = cmd.clear ? '0 : write_data[WORD_BITS-1:0];
		status_d  = ST_DONE;
		rd_ok_d   = 1'b0;
		if (cmd.clear) begin
			mem_we = 1'b1;
		end else if (cmd.accept) begin
			if (mode_q) begin
				if (!is_read) begin
					mem_we    = 1'b1;
					mem_waddr = AW'({w_pair, w_slot});
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'({r_pair, r_slot});
					rd_ok_d   = 1'b1;
				end
			end else if (!is_read) begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = wp_q;
				end
			end else begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					mem_re  = 1'b1;
					rd_ok_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			depth_q   <= DEPTH_RESET;
			wp_q      <= '0;
			rp_q      <= '0;
			fill_q    <= '0;
			latest_q  <= 1'b0;
			reading_q <= 1'b0;
			newest_q  <= '0;
			clr_ptr_q <= '0;
			status_q  <= ST_DONE;
			rd_ok_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:  mode_q  <= cfg_wdata[0];
					CFG_DEPTH: depth_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.clear && !sts.clear_done) begin
				clr_ptr_q <= clr_ptr_q + AW'(1);
			end
			if (cmd.accept) begin
				status_q <= status_d;
				rd_ok_q  <= rd_ok_d;
				if (mode_q) begin
					if (!is_read) begin
						newest_q[w_pair] <= w_slot;
						latest_q         <= w_pair;
					end else begin
						reading_q <= r_pair;
					end
				end else if (!is_read && !full) begin
					wp_q   <= wp_next;
					fill_q <= fill_q + CW'(1);
				end else if (is_read && !empty) begin
					rp_q   <= rp_next;
					fill_q <= fill_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_raddr];
		end
	end

	assign sts.clear_done = (clr_ptr_q == AW'(DEPTH - 1));
	assign read_data      = rd_ok_q ? FIELD_BITS'(mem_rd_q) : '0;
	assign status         = status_q;

	`DMSB_ASSERT_NOW(a_fill_bounded, 1'b1, fill_q <= CW'(DEPTH), "fill count above depth")
	`DMSB_ASSERT_NEXT(a_refused_write_holds, cmd.accept && !mode_q && !is_read && full, $stable(wp_q) && $stable(fill_q), "refused write moved ring state")
	`DMSB_ASSERT_NOW(a_read_data_only_done, rd_ok_q, status_q == ST_DONE, "read data shown with refusal status")

endmodule

// ===== tb/tb_dual_mode_slot_buffer.sv =====
// Self-checking testbench for dual_mode_slot_buffer: ring FIFO and four-slot modes.
// Depends on dmsb_pkg, dmsb_in_if, dmsb_out_if and the dual_mode_slot_buffer RTL.
// A built-in behavioral model predicts every response and checks it field by field.
module tb_dual_mode_slot_buffer;
	timeunit 1ns;
	timeprecision 1ps;

	import dmsb_pkg::*;

	localparam int SLOTS       = 16;
	localparam int QUIET_LIMIT = 4000;	// cycles with no transfer before giving up
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [FIELD_BITS-1:0] read_data;
		status_t               status;
	} resp_t;

	// One step of the plan: a request transfer, a register write, a change of
	// pacing, or a hold until every outstanding response has come back.
	typedef enum logic [1:0] {
		STEP_REQ,
		STEP_CFG,
		STEP_PACE,
		STEP_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		op_t                   op;
		logic [FIELD_BITS-1:0] word;
		cfg_idx_t              reg_idx;
		logic [CFG_DATA_BITS-1:0] reg_val;
		int                    src_gap_pct;
		int                    snk_stall_pct;
	} plan_step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	dmsb_in_if  req_ch ();
	dmsb_out_if rsp_ch ();

	dual_mode_slot_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Behavioral model of the buffer: shared store, ring pointers, and the
	// four-slot pair/slot bookkeeping. Config copy mirrors the registers.
	// ------------------------------------------------------------------
	logic [FIELD_BITS-1:0] store_m [SLOTS];
	logic [3:0] wr_ptr_m;
	logic [3:0] rd_ptr_m;
	logic [4:0] fill_m;
	logic       latest_pair_m;
	logic       reading_pair_m;
	logic       newest_slot_m [2];
	logic       four_slot_m;
	logic [CFG_DATA_BITS-1:0] depth_reg_m;

	plan_step_t request_plan [$];
	resp_t      due_responses [$];

	int  src_gap_pct;	// sender idles this many cycles in a hundred
	int  snk_stall_pct;	// receiver stalls this many cycles in a hundred
	int  planned_reqs;
	int  checked_rsps;
	int  fail_count;
	int  quiet_cycles;
	logic req_fired;	// request transfer at the most recent rising edge

	// Depth 0 behaves as 1, anything past the store size as the store size.
	function automatic logic [4:0] depth_in_effect();
		if (depth_reg_m == '0)
			return 5'd1;
		if (depth_reg_m > 5'(SLOTS))
			return 5'(SLOTS);
		return depth_reg_m;
	endfunction

	// Pointer advance wraps once it reaches the depth in use; a pointer left
	// past a smaller depth also wraps to 0 on its next move.
	function automatic logic [3:0] ring_next(logic [3:0] ptr, logic [4:0] depth);
		return ({1'b0, ptr} + 5'd1 >= depth) ? 4'd0 : ptr + 4'd1;
	endfunction

	function automatic resp_t buffer_response(op_t op, logic [FIELD_BITS-1:0] word);
		resp_t      r;
		logic       pair;
		logic       slot;
		logic [4:0] depth;
		r.read_data = '0;
		r.status    = ST_DONE;
		depth       = depth_in_effect();
		if (four_slot_m) begin
			if (op == OP_WRITE) begin
				// writer takes the pair the reader is not on, and the older slot
				pair = ~reading_pair_m;
				slot = ~newest_slot_m[pair];
				store_m[{pair, slot}] = word;
				newest_slot_m[pair]   = slot;
				latest_pair_m         = pair;
			end else begin
				pair           = latest_pair_m;
				reading_pair_m = pair;
				r.read_data    = store_m[{pair, newest_slot_m[pair]}];
			end
		end else if (op == OP_WRITE) begin
			if (fill_m >= depth)
				r.status = ST_FULL;
			else begin
				store_m[wr_ptr_m] = word;
				wr_ptr_m = ring_next(wr_ptr_m, depth);
				fill_m   = fill_m + 5'd1;
			end
		end else begin
			if (fill_m == '0)
				r.status = ST_EMPTY;
			else begin
				r.read_data = store_m[rd_ptr_m];
				rd_ptr_m = ring_next(rd_ptr_m, depth);
				fill_m   = fill_m - 5'd1;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Plan builders
	// ------------------------------------------------------------------
	function automatic void plan_req(op_t op, logic [FIELD_BITS-1:0] word);
		plan_step_t s;
		s.kind = STEP_REQ;
		s.op   = op;
		s.word = word;
		request_plan.push_back(s);
		planned_reqs++;
	endfunction

	function automatic void plan_cfg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
		plan_step_t s;
		s.kind    = STEP_CFG;
		s.reg_idx = idx;
		s.reg_val = val;
		request_plan.push_back(s);
	endfunction

	function automatic void plan_pace(int gap_pct, int stall_pct);
		plan_step_t s;
		s.kind          = STEP_PACE;
		s.src_gap_pct   = gap_pct;
		s.snk_stall_pct = stall_pct;
		request_plan.push_back(s);
	endfunction

	// ------------------------------------------------------------------
	// Driver: all inputs change on the falling edge. Each signal gets one
	// nonblocking assignment per edge, from locals worked out first.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		plan_step_t step;
		logic       nxt_valid;
		op_t        nxt_op;
		logic [FIELD_BITS-1:0] nxt_word;
		logic       nxt_we;
		cfg_idx_t   nxt_idx;
		logic [CFG_DATA_BITS-1:0] nxt_wdata;
		logic       stop;

		nxt_valid = req_ch.valid;
		nxt_op    = op_t'(req_ch.operation);
		nxt_word  = req_ch.write_data;
		nxt_we    = 1'b0;
		nxt_idx   = cfg_index;
		nxt_wdata = cfg_wdata;
		stop      = 1'b0;

		if (arst_n) begin
			// a request still waiting for its transfer is held as it is
			if (!req_ch.valid || req_fired) begin
				nxt_valid = 1'b0;
				while (!stop && request_plan.size() > 0) begin
					step = request_plan[0];
					case (step.kind)
						STEP_PACE: begin
							src_gap_pct   = step.src_gap_pct;
							snk_stall_pct = step.snk_stall_pct;
							void'(request_plan.pop_front());
						end
						STEP_DRAIN: begin
							if (due_responses.size() == 0)
								void'(request_plan.pop_front());
							else
								stop = 1'b1;
						end
						STEP_CFG: begin
							// registers only change with nothing in flight
							if (due_responses.size() == 0) begin
								nxt_we    = 1'b1;
								nxt_idx   = step.reg_idx;
								nxt_wdata = step.reg_val;
								void'(request_plan.pop_front());
							end
							stop = 1'b1;
						end
						default: begin
							if ($urandom_range(0, 99) >= src_gap_pct) begin
								nxt_valid = 1'b1;
								nxt_op    = step.op;
								nxt_word  = step.word;
								void'(request_plan.pop_front());
							end
							stop = 1'b1;
						end
					endcase
				end
			end
		end

		req_ch.valid      <= nxt_valid;
		req_ch.operation  <= nxt_op;
		req_ch.write_data <= nxt_word;
		cfg_we            <= nxt_we;
		cfg_index         <= nxt_idx;
		cfg_wdata         <= nxt_wdata;
		rsp_ch.ready      <= arst_n && ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// ------------------------------------------------------------------
	// Monitor: samples both channels and the config port on the rising edge.
	// The response to a request comes in the cycle after it at the earliest, so
	// the response check goes before this edge's request is predicted.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		resp_t want;
		logic  busy;
		if (arst_n) begin
			busy = 1'b0;
			if (rsp_ch.valid && rsp_ch.ready) begin
				busy = 1'b1;
				checked_rsps++;
				if (due_responses.size() == 0) begin
					$display("%0t unexpected response: expected none, actual data %h status %0d",
						$realtime, rsp_ch.read_data, rsp_ch.status);
					fail_count++;
				end else begin
					want = due_responses.pop_front();
					if (rsp_ch.read_data !== want.read_data) begin
						$display("%0t read_data mismatch: expected %h actual %h",
							$realtime, want.read_data, rsp_ch.read_data);
						fail_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$display("%0t status mismatch: expected %0d actual %0d",
							$realtime, want.status, rsp_ch.status);
						fail_count++;
					end
				end
			end

			if (cfg_we) begin
				busy = 1'b1;
				if (cfg_index == CFG_MODE)
					four_slot_m = cfg_wdata[0];
				else
					depth_reg_m = cfg_wdata;
			end

			req_fired = req_ch.valid && req_ch.ready;
			if (req_fired) begin
				busy = 1'b1;
				due_responses.push_back(
					buffer_response(op_t'(req_ch.operation), req_ch.write_data));
			end

			// watchdog: a run that stops moving is a failure
			quiet_cycles = busy ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus plan, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		logic       slot_mode;
		logic [4:0] depth_pick;
		op_t        run_op;
		op_t        op;
		int         left;
		int         run_len;
		logic [FIELD_BITS-1:0] word;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_WRITE;
		req_ch.write_data = '0;
		rsp_ch.ready      = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_MODE;
		cfg_wdata         = '0;

		foreach (store_m[i])
			store_m[i] = '0;
		wr_ptr_m         = '0;
		rd_ptr_m         = '0;
		fill_m           = '0;
		latest_pair_m    = 1'b0;
		reading_pair_m   = 1'b0;
		newest_slot_m[0] = 1'b0;
		newest_slot_m[1] = 1'b0;
		four_slot_m      = 1'b0;
		depth_reg_m      = DEPTH_RESET;

		src_gap_pct   = 0;
		snk_stall_pct = 0;
		planned_reqs  = 0;
		checked_rsps  = 0;
		fail_count    = 0;
		quiet_cycles  = 0;
		req_fired     = 1'b0;

		// Directed: ring mode at reset depth, empty read, field extremes
		plan_pace(0, 0);
		plan_req(OP_READ,  64'h0);
		plan_req(OP_WRITE, 64'h0);
		plan_req(OP_WRITE, '1);
		plan_req(OP_WRITE, 64'h5555_5555_5555_5555);
		plan_req(OP_READ,  '1);
		plan_req(OP_READ,  64'h0);
		plan_req(OP_READ,  64'h0);
		plan_req(OP_READ,  64'h0);
		// depth 0 behaves as one entry: second write is refused
		plan_cfg(CFG_DEPTH, 5'd0);
		plan_req(OP_WRITE, 64'hAAAA_AAAA_AAAA_AAAA);
		plan_req(OP_WRITE, 64'h1);
		plan_req(OP_READ,  64'h0);
		plan_req(OP_READ,  64'h0);
		// depth past the store size, then four-slot mode; the first read
		// comes before any four-slot write and sees what the ring left there
		plan_cfg(CFG_DEPTH, 5'd31);
		plan_cfg(CFG_MODE, 5'b11111);
		plan_req(OP_READ,  64'h0);
		plan_req(OP_WRITE, '1);
		plan_req(OP_READ,  64'h0);
		plan_req(OP_WRITE, 64'h8000_0000_0000_0001);
		plan_req(OP_WRITE, 64'h0123_4567_89AB_CDEF);
		plan_req(OP_READ,  64'h0);
		plan_req(OP_WRITE, 64'hFEDC_BA98_7654_3210);
		plan_req(OP_READ,  64'h0);
		plan_cfg(CFG_MODE, 5'b11110);

		// Random: 24 segments, each with fresh registers and runs of one
		// operation so the ring fills, wraps and empties. Pointers and fill
		// level carry over between segments, as do the four-slot bits.
		run_op = OP_WRITE;
		for (int seg = 0; seg < 24; seg++) begin
			if (seg == 0)
				plan_pace(30, 83);
			else if (seg == 8)
				plan_pace(83, 30);
			else if (seg == 16)
				plan_pace(0, 0);

			slot_mode = ($urandom_range(0, 9) < 3);
			case ($urandom_range(0, 7))
				0:       depth_pick = 5'd0;
				1:       depth_pick = 5'd1;
				2:       depth_pick = 5'd16;
				3:       depth_pick = 5'd31;
				4:       depth_pick = 5'($urandom_range(17, 30));
				default: depth_pick = 5'($urandom_range(2, 15));
			endcase
			plan_cfg(CFG_MODE, {4'($urandom), slot_mode});
			plan_cfg(CFG_DEPTH, depth_pick);

			left = 52;
			while (left > 0) begin
				run_len = slot_mode ? $urandom_range(1, 4) : $urandom_range(1, 18);
				for (int k = 0; k < run_len && left > 0; k++) begin
					op = run_op;
					if ($urandom_range(0, 9) == 0)
						op = (op == OP_WRITE) ? OP_READ : OP_WRITE;
					case ($urandom_range(0, 15))
						0:       word = '0;
						1:       word = '1;
						default: word = {$urandom, $urandom};
					endcase
					plan_req(op, word);
					left--;
					// once per pacing phase, hold off until all responses are back
					if (seg % 8 == 3 && left == 26) begin
						plan_step_t hold;
						hold.kind = STEP_DRAIN;
						request_plan.push_back(hold);
					end
				end
				run_op = (run_op == OP_WRITE) ? OP_READ : OP_WRITE;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (checked_rsps < planned_reqs || due_responses.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/dmsb_pkg.sv
design/dmsb_in_if.sv
design/dmsb_out_if.sv
design/dmsb_ctrl.sv
design/dmsb_dp.sv
design/dual_mode_slot_buffer.sv
tb/tb_dual_mode_slot_buffer.sv
